[rtl/agcen_pkg.sv]
package agcen_pkg;

   // Time base and decay window.
   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned DECAY_STEP = 10;

   // Q1.16 level format.
   localparam int unsigned LEVEL_W = 17;
   localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [LEVEL_W-1:0] DECAY_MIN = 17'd7;

   // The decay factor is (FACTOR_BASE + decay) / (65536 * 100).
   localparam int unsigned FACTOR_W = 23;
   localparam logic [FACTOR_W-1:0] FACTOR_BASE = 23'd6488064;

   // Shared multiplier.
   localparam int unsigned MUL_W = 24;
   localparam int unsigned PROD_W = 2 * MUL_W;

   // floor(q / 100) for q below 2^23 is exactly (q * RECIP_100) >> RECIP_SHIFT.
   localparam logic [MUL_W-1:0] RECIP_100 = 24'd10737419;
   localparam int unsigned RECIP_SHIFT = 30;

   // Bit-serial divider: the quotient never exceeds 17 bits.
   localparam int unsigned DIV_STEPS = LEVEL_W;
   localparam int unsigned DIVIDEND_W = 2 * LEVEL_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HIGH_MUL,
      S_HIGH_RCP,
      S_HIGH,
      S_LOW_MUL,
      S_LOW_RCP,
      S_LOW,
      S_DIV,
      S_NORM,
      S_MAP,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_HIGH,
      MUL_RECIP,
      MUL_SPAN,
      MUL_MAP
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        hi_en;
      logic        lo_en;
      logic        div_step;
      logic        quot_en;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic span_zero;
   } status_type;

endpackage

[rtl/agcen_div.sv]
module agcen_div (
   input  logic                               clock,
   input  logic                               load,
   input  logic                               step,
   input  logic [agcen_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [agcen_pkg::LEVEL_W-1:0]      divisor,
   output logic [agcen_pkg::LEVEL_W-1:0]      quotient
);
   import agcen_pkg::*;

   // The upper half of the dividend is below the divisor, so the partial
   // remainder starts there and one quotient bit comes out per step.
   logic [LEVEL_W:0]   rem_ff, rem_in;
   logic [LEVEL_W-1:0] bits_ff, bits_in;
   logic [LEVEL_W-1:0] dvs_ff, dvs_in;
   logic [LEVEL_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[LEVEL_W-1:0], bits_ff[LEVEL_W-1]};
      if (load) begin
         rem_in  = {1'b0, dividend[DIVIDEND_W-1:LEVEL_W]};
         bits_in = dividend[LEVEL_W-1:0];
         dvs_in  = divisor;
      end else if (step) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            bits_in = {bits_ff[LEVEL_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            bits_in = {bits_ff[LEVEL_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient = bits_ff;

endmodule

[rtl/agcen_dp.sv]
module agcen_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  agcen_pkg::cmd_type                   cmd,
   output agcen_pkg::status_type                status,
   input  logic [agcen_pkg::TIME_WIDTH-1:0]     req_time_stamp,
   input  logic [agcen_pkg::LEVEL_W-1:0]        req_sample,
   input  logic                                 csr_we,
   input  logic [agcen_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [agcen_pkg::LEVEL_W-1:0]        csr_wdata,
   output logic [agcen_pkg::LEVEL_W-1:0]        rsp_level,
   output logic                                 rsp_span_zero
);
   import agcen_pkg::*;

   // Configuration registers.
   logic [LEVEL_W-1:0] out_max_ff, out_max_in;
   logic [LEVEL_W-1:0] out_min_ff, out_min_in;
   logic [LEVEL_W-1:0] decay_ff, decay_in;

   // Tracking state.
   logic [LEVEL_W-1:0]    peak_high_ff, peak_high_in;
   logic [LEVEL_W-1:0]    peak_low_ff, peak_low_in;
   logic [TIME_WIDTH-1:0] decay_time_ff, decay_time_in;

   // Per-transaction working registers.
   logic [LEVEL_W-1:0]  x_ff, x_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [LEVEL_W-1:0]  hi_ff, hi_in;
   logic [LEVEL_W-1:0]  span_ff, span_in;
   logic [LEVEL_W-1:0]  n_ff, n_in;
   logic                flag_ff, flag_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                span_zero_ff, span_zero_in;

   logic [TIME_WIDTH:0]  time_sum;
   logic                 in_window;
   logic [LEVEL_W-1:0]   x_sat, d_sat, d_eff;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [LEVEL_W-1:0]   scaled;
   logic [LEVEL_W-1:0]   hi_calc, lo_raw, lo_calc;
   logic                 zero_span;
   logic                 ordered;
   logic [LEVEL_W-1:0]   map_a, map_diff, map_base;
   logic [LEVEL_W:0]     level_sum;
   logic [DIVIDEND_W-1:0] dividend;
   logic [LEVEL_W-1:0]   divisor, quotient;

   agcen_div u_div (
      .clock    (clock),
      .load     (cmd.lo_en),
      .step     (cmd.div_step),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient)
   );

   // Window test against the stored time; a carry out of the sum is kept.
   assign time_sum  = {1'b0, decay_time_ff} + (TIME_WIDTH + 1)'(DECAY_STEP);
   assign in_window = time_sum >= {1'b0, req_time_stamp};
   assign x_sat     = (req_sample > ONE_Q16) ? ONE_Q16 : req_sample;
   assign d_sat     = (decay_ff > ONE_Q16) ? ONE_Q16 : decay_ff;
   assign d_eff     = in_window ? d_sat : ONE_Q16;

   assign status.bypass    = in_window && (decay_ff < DECAY_MIN);

   // Floor of a product with the factor, after the reciprocal multiply.
   assign scaled  = prod_ff[RECIP_SHIFT +: LEVEL_W];
   assign hi_calc = (scaled > x_ff) ? scaled : x_ff;
   assign lo_raw  = hi_ff - scaled;
   assign lo_calc = (lo_raw < x_ff) ? lo_raw : x_ff;
   assign zero_span = hi_ff <= lo_calc;
   assign status.span_zero = zero_span;

   assign dividend = {1'b0, x_ff - lo_calc, {(LEVEL_W - 1){1'b0}}};
   assign divisor  = hi_ff - lo_calc;

   assign ordered  = out_min_ff < out_max_ff;
   assign map_a    = ordered ? n_ff : ONE_Q16 - n_ff;
   assign map_diff = ordered ? out_max_ff - out_min_ff : out_min_ff - out_max_ff;
   assign map_base = ordered ? out_min_ff : out_max_ff;
   assign level_sum = {1'b0, prod_ff[16 +: LEVEL_W]} + {1'b0, map_base};

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_HIGH: begin
            mul_a = MUL_W'(peak_high_ff);
            mul_b = MUL_W'(factor_ff);
         end
         MUL_RECIP: begin
            mul_a = MUL_W'(prod_ff[16 +: FACTOR_W]);
            mul_b = RECIP_100;
         end
         MUL_SPAN: begin
            mul_a = MUL_W'(span_ff);
            mul_b = MUL_W'(factor_ff);
         end
         MUL_MAP: begin
            mul_a = MUL_W'(map_a);
            mul_b = MUL_W'(map_diff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      out_max_in    = out_max_ff;
      out_min_in    = out_min_ff;
      decay_in      = decay_ff;
      peak_high_in  = peak_high_ff;
      peak_low_in   = peak_low_ff;
      decay_time_in = decay_time_ff;
      x_in          = x_ff;
      factor_in     = factor_ff;
      hi_in         = hi_ff;
      span_in       = span_ff;
      n_in          = n_ff;
      flag_in       = flag_ff;
      prod_in       = prod_ff;
      level_in      = level_ff;
      span_zero_in  = span_zero_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_OUT_MAX: out_max_in = csr_wdata;
            CSR_OUT_MIN: out_min_in = csr_wdata;
            CSR_DECAY:   decay_in   = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         x_in      = x_sat;
         factor_in = FACTOR_BASE + FACTOR_W'(d_eff);
         n_in      = x_sat;
         flag_in   = 1'b0;
         if (in_window) begin
            decay_time_in = time_sum[TIME_WIDTH-1:0];
         end
         if (status.bypass) begin
            peak_high_in = ONE_Q16;
            peak_low_in  = '0;
         end
      end

      if (cmd.mul_en) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      if (cmd.hi_en) begin
         hi_in   = hi_calc;
         span_in = (hi_calc > peak_low_ff) ? hi_calc - peak_low_ff : '0;
      end

      if (cmd.lo_en) begin
         peak_high_in = hi_ff;
         peak_low_in  = lo_calc;
         flag_in      = zero_span;
         n_in         = '0;
      end

      if (cmd.quot_en) begin
         n_in = (quotient > ONE_Q16) ? ONE_Q16 : quotient;
      end

      if (cmd.out_load) begin
         level_in     = level_sum[LEVEL_W-1:0];
         span_zero_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_max_ff    <= ONE_Q16;
         out_min_ff    <= '0;
         decay_ff      <= 17'd32768;
         peak_high_ff  <= ONE_Q16;
         peak_low_ff   <= '0;
         decay_time_ff <= '0;
      end else begin
         out_max_ff    <= out_max_in;
         out_min_ff    <= out_min_in;
         decay_ff      <= decay_in;
         peak_high_ff  <= peak_high_in;
         peak_low_ff   <= peak_low_in;
         decay_time_ff <= decay_time_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      factor_ff    <= factor_in;
      hi_ff        <= hi_in;
      span_ff      <= span_in;
      n_ff         <= n_in;
      flag_ff      <= flag_in;
      prod_ff      <= prod_in;
      level_ff     <= level_in;
      span_zero_ff <= span_zero_in;
   end

   assign rsp_level     = level_ff;
   assign rsp_span_zero = span_zero_ff;

endmodule

[rtl/agcen_ctrl.sv]
module agcen_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  agcen_pkg::status_type    status,
   output agcen_pkg::cmd_type       cmd
);
   import agcen_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = MUL_HIGH;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = status.bypass ? S_MAP : S_HIGH_MUL;
            end
         end
         S_HIGH_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HIGH;
            state_in    = S_HIGH_RCP;
         end
         S_HIGH_RCP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RECIP;
            state_in    = S_HIGH;
         end
         S_HIGH: begin
            cmd.hi_en = 1'b1;
            state_in  = S_LOW_MUL;
         end
         S_LOW_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SPAN;
            state_in    = S_LOW_RCP;
         end
         S_LOW_RCP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RECIP;
            state_in    = S_LOW;
         end
         S_LOW: begin
            cmd.lo_en = 1'b1;
            cnt_in    = '0;
            state_in  = status.span_zero ? S_MAP : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            cmd.quot_en = 1'b1;
            state_in    = S_MAP;
         end
         S_MAP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MAP;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // Wait here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/agc_envelope_normalizer_unit.sv]
// Peak-tracking gain control: each transaction carries a time stamp and a Q1.16
// sample; the unit keeps a decaying peak maximum and minimum, normalizes the
// sample into that span and maps it onto [out_min, out_max] (inverted when out_min
// is not below out_max), returning one level and a zero-span flag per transaction.
// With tracking active a transaction runs through the states on the single
// shared 24x24 multiplier and peak update (high multiply, reciprocal, high,
// low multiply, reciprocal, low), then the one-bit-per-cycle divider, then
// normalize, map and output load before the next acceptance. When the peak span
// collapses to zero the divider and normalize steps are skipped. With tracking
// disabled (decay below 7 inside the time window) only map and output load
// follow the capture. The result sits in an output register, so a stalled
// consumer holds up the unit only when a second result is ready to be loaded.
module agc_envelope_normalizer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [agcen_pkg::TIME_WIDTH-1:0]     req_time_stamp,
   input  logic [agcen_pkg::LEVEL_W-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [agcen_pkg::LEVEL_W-1:0]        rsp_level,
   output logic                                 rsp_span_zero,
   input  logic                                 csr_we,
   input  logic [agcen_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [agcen_pkg::LEVEL_W-1:0]        csr_wdata
);
   import agcen_pkg::*;

   cmd_type    cmd;
   status_type status;

   agcen_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   agcen_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_time_stamp (req_time_stamp),
      .req_sample     (req_sample),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_level      (rsp_level),
      .rsp_span_zero  (rsp_span_zero)
   );

   // A captured transaction keeps the input closed in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ready)
      else $error("input accepted again right after a capture");

   // The output register is loaded only when it is empty or being drained.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result overwrote an undelivered transaction");

   // Datapath update steps never overlap.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.hi_en, cmd.lo_en, cmd.quot_en, cmd.out_load,
                cmd.div_step}))
      else $error("overlapping datapath commands");

   // A loaded result is presented in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not presented");

endmodule
